// ===== hdl/wpa_pkg.sv =====
`default_nettype none
package wpa_pkg;
	localparam int MaxSources = 8;
	localparam int SampleW = 16;
	localparam int WeightW = 16;
	localparam int ProdW = 33;
	localparam int SumW = 36;
	localparam int DivW = 24;
	localparam int DivSteps = SumW;
	localparam int CntW = 4;
	localparam int DepthW = 5;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 64;

	localparam logic [CfgIdxW-1:0] RegWeightsLow = 3'd0;
	localparam logic [CfgIdxW-1:0] RegWeightsHigh = 3'd1;
	localparam logic [CfgIdxW-1:0] RegSourceCount = 3'd2;
	localparam logic [CfgIdxW-1:0] RegDivisor = 3'd3;
	localparam logic [CfgIdxW-1:0] RegBitDepth = 3'd4;
	localparam logic [CfgIdxW-1:0] RegChromaMode = 3'd5;

	typedef struct packed {
		logic [MaxSources*WeightW-1:0] weights;
		logic [CntW-1:0] count;
		logic [DivW-1:0] divisor;
		logic [DepthW-1:0] depth;
		logic chroma;
	} cfg_t;

	typedef struct packed {
		logic neg;
		logic [SumW-1:0] rem;
		logic [SumW-1:0] quo;
	} div_t;
endpackage
`default_nettype wire

// ===== hdl/wpa_mac.sv =====
`default_nettype none
module wpa_mac
	import wpa_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic in_valid,
	input  wire logic [MaxSources*SampleW-1:0] samples,
	input  wire cfg_t cfg,
	output logic out_valid,
	output logic [SumW-1:0] sum_mag,
	output logic sum_neg
);
	logic signed [ProdW-1:0] prod_s1 [MaxSources];
	logic valid_s1, valid_s2;
	logic signed [SumW-1:0] sum_s2;
	logic signed [SumW-1:0] acc;
	logic [SampleW-1:0] centre;

	always_comb begin
		centre = '0;
		if (cfg.chroma) centre = SampleW'(1) << (cfg.depth - DepthW'(1));
		acc = '0;
		for (int k = 0; k < MaxSources; k++) acc = acc + SumW'(prod_s1[k]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < MaxSources; k++) begin
				if (k < cfg.count)
					prod_s1[k] <= ProdW'($signed(cfg.weights[k*WeightW +: WeightW])) *
						ProdW'($signed({1'b0, samples[k*SampleW +: SampleW]}) -
						$signed({1'b0, centre}));
				else
					prod_s1[k] <= '0;
			end
			sum_s2 <= acc;
		end
	end

	assign out_valid = valid_s2;
	assign sum_neg = sum_s2[SumW-1];
	assign sum_mag = sum_neg ? SumW'(-sum_s2) : sum_s2;
endmodule
`default_nettype wire

// ===== hdl/wpa_div.sv =====
`default_nettype none
module wpa_div
	import wpa_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic in_valid,
	input  wire logic [SumW-1:0] mag,
	input  wire logic neg,
	input  wire logic [DivW-1:0] den,
	output logic out_valid,
	output div_t res
);
	logic [DivSteps:1] valid_q;
	div_t first;
	div_t stg_q [1:DivSteps];

	always_comb begin
		first = '0;
		first.neg = neg;
		first.quo = mag;
	end

	for (genvar i = 0; i < DivSteps; i++) begin : g_step
		div_t cur;
		div_t nxt;
		logic [SumW:0] trial;
		if (i == 0) begin : g_head
			assign cur = first;
		end else begin : g_tail
			assign cur = stg_q[i];
		end
		always_comb begin
			trial = {cur.rem, cur.quo[SumW-1]} - (SumW+1)'(den);
			nxt = cur;
			if (!trial[SumW]) begin
				nxt.rem = trial[SumW-1:0];
				nxt.quo = {cur.quo[SumW-2:0], 1'b1};
			end else begin
				nxt.rem = {cur.rem[SumW-2:0], cur.quo[SumW-1]};
				nxt.quo = {cur.quo[SumW-2:0], 1'b0};
			end
		end
		always_ff @(posedge clk) begin
			if (en) stg_q[i+1] <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= '0;
		else if (en) valid_q <= {valid_q[DivSteps-1:1], in_valid};
	end

	assign out_valid = valid_q[DivSteps];
	assign res = stg_q[DivSteps];
endmodule
`default_nettype wire

// ===== hdl/weighted_pixel_average_core.sv =====
// Weighted pixel average of up to eight co-located source samples.
// Channels: s_axis carries one pixel position per beat (sample_0 in the
// low 16 bits up to sample_7 in bits 127:112); m_axis returns the blended
// pixel in tdata[15:0]. cfg writes registers 0..5 (weights low/high,
// source count, divisor, bit depth, chroma mode); the user must do so only
// while the block is idle, as the block itself does not enforce it.
// Throughput: one beat per cycle while the receiver does not stall.
// Pipeline: 39 register stages (two multiply/sum stages, a 36-stage
// restoring divider, a round/clamp stage); the divider sets the latency.
// Reset clears all valid bits and loads register defaults (count 1,
// divisor 1, depth 8, luma, zero weights).
// When the receiver stalls the whole pipeline holds; s_axis_tready falls
// whenever a finished beat waits at m_axis while m_axis_tready is low.
`default_nettype none
module weighted_pixel_average_core
	import wpa_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input  wire logic [MaxSources*SampleW-1:0] s_axis_tdata, // sample_0..sample_7
	output logic m_axis_tvalid,
	input  wire logic m_axis_tready,
	output logic [15:0] m_axis_tdata, // blended_pixel
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic [CfgIdxW-1:0] cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_data
);
	logic [CfgDataW-1:0] wlo_q, whi_q;
	logic [CntW-1:0] cnt_q;
	logic [DivW-1:0] div_q;
	logic [DepthW-1:0] dep_q;
	logic chroma_q;
	cfg_t cfg;
	logic en, mac_v, div_v, out_v_q;
	logic [SumW-1:0] mag;
	logic neg;
	div_t dres;
	logic [SumW:0] q;
	logic [SumW+1:0] rem2;
	logic signed [SumW+1:0] sq, lo, hi;
	logic [15:0] centre, pix_q;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlo_q <= '0; whi_q <= '0; cnt_q <= CntW'(1);
			div_q <= DivW'(1); dep_q <= DepthW'(8); chroma_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				RegWeightsLow: wlo_q <= cfg_data;
				RegWeightsHigh: whi_q <= cfg_data;
				RegSourceCount: cnt_q <= cfg_data[CntW-1:0];
				RegDivisor: div_q <= cfg_data[DivW-1:0];
				RegBitDepth: dep_q <= cfg_data[DepthW-1:0];
				RegChromaMode: chroma_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.weights = {whi_q, wlo_q};
		cfg.count = (cnt_q > CntW'(MaxSources)) ? CntW'(MaxSources) : cnt_q;
		cfg.divisor = (div_q == '0) ? DivW'(1) : div_q;
		cfg.depth = (dep_q < DepthW'(8)) ? DepthW'(8) :
			(dep_q > DepthW'(16)) ? DepthW'(16) : dep_q;
		cfg.chroma = chroma_q;
	end

	assign en = !out_v_q || m_axis_tready;
	assign s_axis_tready = en;

	wpa_mac u_mac (.clk, .arst_n, .en, .in_valid(s_axis_tvalid && s_axis_tready),
		.samples(s_axis_tdata), .cfg, .out_valid(mac_v), .sum_mag(mag), .sum_neg(neg));

	wpa_div u_div (.clk, .arst_n, .en, .in_valid(mac_v), .mag, .neg,
		.den(cfg.divisor), .out_valid(div_v), .res(dres));

	always_comb begin
		rem2 = {1'b0, dres.rem, 1'b0};
		q = {1'b0, dres.quo};
		if (rem2 > (SumW+2)'(cfg.divisor) ||
			(rem2 == (SumW+2)'(cfg.divisor) && dres.quo[0]))
			q = q + (SumW+1)'(1);
		sq = dres.neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
		centre = '0;
		if (cfg.chroma) centre = 16'(1) << (cfg.depth - DepthW'(1));
		lo = -$signed((SumW+2)'(centre));
		hi = $signed((SumW+2)'((17'(1) << cfg.depth) - 17'(1))) -
			$signed((SumW+2)'(centre));
		if (sq < lo) sq = lo;
		if (sq > hi) sq = hi;
		sq = sq + $signed((SumW+2)'(centre));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (en) out_v_q <= div_v;
	end
	always_ff @(posedge clk) begin
		if (en) pix_q <= sq[15:0];
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = pix_q;

`ifndef NO_ASSERTIONS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output beat changed under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (32'(m_axis_tdata) >> cfg.depth) == 0)
		else $error("pixel out of depth range");
`endif
endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none
module testbench;
	import wpa_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	wire logic s_axis_tready;
	logic [MaxSources*SampleW-1:0] s_axis_tdata = '0; // sample_0..sample_7
	wire logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	wire logic [15:0] m_axis_tdata; // blended_pixel
	logic cfg_valid = 1'b0;
	wire logic cfg_ready;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;

	weighted_pixel_average_core DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	logic [63:0] w_lo, w_hi;
	logic [CntW-1:0] n_src;
	logic [DivW-1:0] div_q;
	logic [DepthW-1:0] depth_q;
	logic chroma_q;

	logic [15:0] pixel_q[$];
	int mismatches = 0;
	int cycles = 0;
	int burst_left = 0;
	int stall_mode = 0;

	function automatic logic [15:0] blend_pixel(input logic [MaxSources*SampleW-1:0] px);
		int unsigned cnt, dep;
		longint den, centre, maxval, acc, mag, q, r, lo, hi, x, w;
		logic [15:0] wraw;
		cnt = (n_src > MaxSources) ? MaxSources : n_src;
		dep = depth_q < 8 ? 8 : (depth_q > 16 ? 16 : depth_q);
		den = (div_q == 0) ? 1 : div_q;
		maxval = (64'd1 << dep) - 1;
		centre = chroma_q ? (64'd1 << (dep - 1)) : 0;
		acc = 0;
		for (int k = 0; k < cnt; k++) begin
			wraw = (k < 4) ? w_lo[16*(k%4) +: 16] : w_hi[16*(k%4) +: 16];
			w = $signed(wraw);
			x = longint'(px[16*k +: 16]) - centre;
			acc += w * x;
		end
		mag = acc < 0 ? -acc : acc;
		q = mag / den;
		r = mag % den;
		if (2*r > den || (2*r == den && q[0]))
			q++;
		if (acc < 0)
			q = -q;
		lo = -centre;
		hi = maxval - centre;
		if (q < lo)
			q = lo;
		if (q > hi)
			q = hi;
		q += centre;
		return q[15:0];
	endfunction

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			RegWeightsLow: w_lo = val;
			RegWeightsHigh: w_hi = val;
			RegSourceCount: n_src = val[CntW-1:0];
			RegDivisor: div_q = val[DivW-1:0];
			RegBitDepth: depth_q = val[DepthW-1:0];
			RegChromaMode: chroma_q = val[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic send_pixel(input logic [MaxSources*SampleW-1:0] px);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap)
					@(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= px;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pixel_q.push_back(blend_pixel(px));
		burst_left--;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pixel_q.size() != 0)
			@(posedge clk);
		repeat (45)
			@(posedge clk);
	endtask

	function automatic logic [MaxSources*SampleW-1:0] rand_pixel(input int dep);
		logic [MaxSources*SampleW-1:0] px;
		for (int k = 0; k < MaxSources; k++)
			px[16*k +: 16] = ($urandom_range(0, 7) == 0) ? 16'($urandom)
				: 16'($urandom_range(0, (1 << dep) - 1));
		return px;
	endfunction

	task automatic apply_setting(input logic [63:0] lo, input logic [63:0] hi, input int cnt,
			input int dv, input int dep, input bit ch);
		write_reg(RegWeightsLow, lo);
		write_reg(RegWeightsHigh, hi);
		write_reg(RegSourceCount, cnt);
		write_reg(RegDivisor, dv);
		write_reg(RegBitDepth, dep);
		write_reg(RegChromaMode, ch);
	endtask

	task automatic test_defaults();
		send_pixel({8{16'hFFFF}});
		send_pixel('0);
		send_pixel({8{16'h5A5A}});
		drain();
	endtask

	task automatic test_extremes();
		apply_setting({4{16'h7FFF}}, {4{16'h7FFF}}, 8, 1, 16, 0);
		send_pixel({8{16'hFFFF}});
		send_pixel('0);
		drain();
		apply_setting({4{16'h8000}}, {4{16'h8000}}, 8, 24'hFFFFFF, 16, 1);
		send_pixel({8{16'hFFFF}});
		send_pixel('0);
		send_pixel({8{16'h8000}});
		drain();
		apply_setting({4{16'h0001}}, {4{16'h0001}}, 0, 1, 8, 1);
		send_pixel({8{16'h1234}});
		drain();
		write_reg(RegChromaMode, 0);
		send_pixel({8{16'h1234}});
		drain();
		apply_setting({4{16'h0001}}, {4{16'hFFFF}}, 15, 0, 31, 0);
		send_pixel({8{16'hABCD}});
		drain();
		apply_setting({4{16'h0001}}, {4{16'h0001}}, 2, 2, 3, 0);
		send_pixel({96'h0, 16'd1, 16'd2});
		send_pixel({96'h0, 16'd1, 16'd4});
		send_pixel({96'h0, 16'd3, 16'd2});
		send_pixel({96'h0, 16'd255, 16'd300});
		drain();
		apply_setting({4{16'h0001}}, {4{16'hFFFF}}, 2, 2, 8, 1);
		send_pixel({96'h0, 16'd127, 16'd128});
		send_pixel({96'h0, 16'd126, 16'd127});
		drain();
	endtask

	task automatic test_random();
		int dep;
		for (int ph = 0; ph < 23; ph++) begin
			dep = $urandom_range(8, 16);
			apply_setting({$urandom, $urandom}, {$urandom, $urandom},
				$urandom_range(0, 15),
				($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 17),
				($urandom_range(0, 5) == 0) ? $urandom_range(0, 31) : dep,
				$urandom_range(0, 1));
			repeat (50)
				send_pixel(rand_pixel(dep));
			drain();
		end
	endtask

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			if (pixel_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat %h", m_axis_tdata);
			end else begin
				if (m_axis_tdata !== pixel_q[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("blended_pixel exp %h got %h", pixel_q[0], m_axis_tdata);
				end
				void'(pixel_q.pop_front());
			end
		end
		if (stall_mode == 0)
			m_axis_tready <= 1'b1;
		else
			m_axis_tready <= ($urandom_range(0, stall_mode) == 0);
		if ($urandom_range(0, 199) == 0)
			stall_mode <= $urandom_range(0, 3);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	initial begin
		w_lo = '0;
		w_hi = '0;
		n_src = 1;
		div_q = 1;
		depth_q = 8;
		chroma_q = 1'b0;
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults();
		test_extremes();
		test_random();
		if (mismatches == 0 && pixel_q.size() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end
endmodule
`default_nettype wire
